// File: rtl/dcsw_pkg.sv
// Shared types, codes and helpers for the display window pixel writer.
`default_nettype none

package dcsw_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic CMD_BLOCK = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [7:0] CFG_COL_OPCODE  = 8'd0;
    localparam logic [7:0] CFG_PAGE_OPCODE = 8'd1;
    localparam logic [7:0] CFG_MW_OPCODE   = 8'd2;

    localparam logic [7:0] RST_COL_OPCODE  = 8'd42;
    localparam logic [7:0] RST_PAGE_OPCODE = 8'd43;
    localparam logic [7:0] RST_MW_OPCODE   = 8'd44;

    // One classified operation handed from the front to the back.
    typedef struct packed {
        logic        is_pixel;
        logic        col_emit;
        logic        page_emit;
        logic        zero_size;
        logic        release_cs;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic [15:0] pixel;
    } op_t;

    typedef enum logic [3:0] {
        PH_START,
        PH_COL_OP,
        PH_COL_SH,
        PH_COL_SL,
        PH_COL_EH,
        PH_COL_EL,
        PH_PG_OP,
        PH_PG_SH,
        PH_PG_SL,
        PH_PG_EH,
        PH_PG_EL,
        PH_MW,
        PH_RED,
        PH_GRN,
        PH_BLU
    } phase_t;

    function automatic logic [7:0] red_byte(input logic [15:0] p);
        red_byte = {p[15:11], p[15:13]};
    endfunction

    function automatic logic [7:0] green_byte(input logic [15:0] p);
        green_byte = {p[10:5], p[10:9]};
    endfunction

    function automatic logic [7:0] blue_byte(input logic [15:0] p);
        blue_byte = {p[4:0], p[4:2]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/dcsw_front.sv
// Front end: accepts words, tracks window cache and pixel count, classifies.
`default_nettype none

module dcsw_front import dcsw_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [15:0] x_start,
    input  wire logic [15:0] y_start,
    input  wire logic [15:0] block_width,
    input  wire logic [15:0] block_height,
    input  wire logic [15:0] pixel_rgb565,
    input  wire logic        q_full,
    output logic             q_push,
    output op_t              q_word
);

    logic [15:0] col_start_reg, col_start_next;
    logic [15:0] col_end_reg, col_end_next;
    logic [15:0] page_start_reg, page_start_next;
    logic [15:0] page_end_reg, page_end_next;
    logic [31:0] remaining_reg, remaining_next;

    logic        accept;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [31:0] count;
    logic        col_diff;
    logic        page_diff;

    assign full   = q_full;
    assign accept = push && !q_full;

    // end = start + size - 1, wrapping at 16 bits
    assign x_end = x_start + block_width + 16'hFFFF;
    assign y_end = y_start + block_height + 16'hFFFF;
    assign count = {16'd0, block_width} * {16'd0, block_height};

    assign col_diff  = (x_start != col_start_reg) || (x_end != col_end_reg);
    assign page_diff = (y_start != page_start_reg) || (y_end != page_end_reg);

    // drop pixels that arrive with no block open
    assign q_push = accept && ((command == CMD_BLOCK) || (remaining_reg != 32'd0));

    always_comb
    begin
        q_word.is_pixel   = (command == CMD_PIXEL);
        q_word.col_emit   = col_diff;
        q_word.page_emit  = page_diff;
        q_word.zero_size  = (count == 32'd0);
        q_word.release_cs = (remaining_reg == 32'd1);
        q_word.x_start    = x_start;
        q_word.x_end      = x_end;
        q_word.y_start    = y_start;
        q_word.y_end      = y_end;
        q_word.pixel      = pixel_rgb565;
    end

    always_comb
    begin
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        page_start_next = page_start_reg;
        page_end_next   = page_end_reg;
        remaining_next  = remaining_reg;
        if (accept)
        begin
            if (command == CMD_BLOCK)
            begin
                col_start_next  = x_start;
                col_end_next    = x_end;
                page_start_next = y_start;
                page_end_next   = y_end;
                remaining_next  = count;
            end
            else if (remaining_reg != 32'd0)
            begin
                remaining_next = remaining_reg - 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_start_reg  <= 16'hFFFF;
            col_end_reg    <= 16'hFFFF;
            page_start_reg <= 16'hFFFF;
            page_end_reg   <= 16'hFFFF;
            remaining_reg  <= 32'd0;
        end
        else
        begin
            col_start_reg  <= col_start_next;
            col_end_reg    <= col_end_next;
            page_start_reg <= page_start_next;
            page_end_reg   <= page_end_next;
            remaining_reg  <= remaining_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dcsw_queue.sv
// Short operation queue between the front and the back.
`default_nettype none

module dcsw_queue import dcsw_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire op_t  wr_word,
    output logic      q_full,
    input  wire logic rd_en,
    output op_t       rd_word,
    output logic      q_empty
);

    op_t                mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_word = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dcsw_back.sv
// Back end: serializes each queued operation into bytes, one per cycle unless stalled.
`default_nettype none

module dcsw_back import dcsw_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire op_t         head,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire logic [7:0]  col_opcode,
    input  wire logic [7:0]  page_opcode,
    input  wire logic [7:0]  mw_opcode,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             is_data,
    output logic             cs_release,
    output logic             last
);

    phase_t      phase_reg, phase_next;
    phase_t      cur_phase;
    phase_t      step_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        data_reg;
    logic        rel_reg;
    logic        last_reg;
    logic        out_free;
    logic        fire;
    logic [7:0]  byte_c;
    logic        data_c;
    logic        rel_c;
    logic        last_c;

    assign out_free = !out_valid_reg || pop;
    assign fire     = !q_empty && out_free;

    // pick the entry phase of a fresh head word
    always_comb
    begin
        if (phase_reg != PH_START)
            cur_phase = phase_reg;
        else if (head.is_pixel)
            cur_phase = PH_RED;
        else if (head.col_emit)
            cur_phase = PH_COL_OP;
        else if (head.page_emit)
            cur_phase = PH_PG_OP;
        else
            cur_phase = PH_MW;
    end

    // next state
    always_comb
    begin
        case (cur_phase)
            PH_COL_OP: step_next = PH_COL_SH;
            PH_COL_SH: step_next = PH_COL_SL;
            PH_COL_SL: step_next = PH_COL_EH;
            PH_COL_EH: step_next = PH_COL_EL;
            PH_COL_EL: step_next = head.page_emit ? PH_PG_OP : PH_MW;
            PH_PG_OP:  step_next = PH_PG_SH;
            PH_PG_SH:  step_next = PH_PG_SL;
            PH_PG_SL:  step_next = PH_PG_EH;
            PH_PG_EH:  step_next = PH_PG_EL;
            PH_PG_EL:  step_next = PH_MW;
            PH_RED:    step_next = PH_GRN;
            PH_GRN:    step_next = PH_BLU;
            default:   step_next = PH_START;
        endcase
        phase_next = fire ? step_next : phase_reg;
    end

    // byte and flags for the current phase
    always_comb
    begin
        byte_c = 8'd0;
        data_c = 1'b1;
        rel_c  = 1'b0;
        last_c = 1'b0;
        case (cur_phase)
            PH_COL_OP:
            begin
                byte_c = col_opcode;
                data_c = 1'b0;
            end
            PH_COL_SH: byte_c = head.x_start[15:8];
            PH_COL_SL: byte_c = head.x_start[7:0];
            PH_COL_EH: byte_c = head.x_end[15:8];
            PH_COL_EL:
            begin
                byte_c = head.x_end[7:0];
                rel_c  = 1'b1;
            end
            PH_PG_OP:
            begin
                byte_c = page_opcode;
                data_c = 1'b0;
            end
            PH_PG_SH: byte_c = head.y_start[15:8];
            PH_PG_SL: byte_c = head.y_start[7:0];
            PH_PG_EH: byte_c = head.y_end[15:8];
            PH_PG_EL:
            begin
                byte_c = head.y_end[7:0];
                rel_c  = 1'b1;
            end
            PH_MW:
            begin
                byte_c = mw_opcode;
                data_c = 1'b0;
                rel_c  = head.zero_size;
                last_c = 1'b1;
            end
            PH_RED: byte_c = red_byte(head.pixel);
            PH_GRN: byte_c = green_byte(head.pixel);
            PH_BLU:
            begin
                byte_c = blue_byte(head.pixel);
                rel_c  = head.release_cs;
                last_c = 1'b1;
            end
            default:
            begin
                byte_c = 8'd0;
                data_c = 1'b0;
            end
        endcase
    end

    assign q_pop = fire && ((cur_phase == PH_MW) || (cur_phase == PH_BLU));

    always_comb
    begin
        if (fire)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the word until it is taken
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_c;
            data_reg <= data_c;
            rel_reg  <= rel_c;
            last_reg <= last_c;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_byte   = byte_reg;
    assign is_data    = data_reg;
    assign cs_release = rel_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// File: rtl/dcs_window_pixel_writer.sv
// Top level of the display window pixel writer: config, front, queue, back.
//
//   channel   handshake            payload
//   input     push / full          command, x_start, y_start, block_width,
//                                  block_height, pixel_rgb565
//   result    empty / pop          out_byte, is_data, cs_release, last
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The back end sends one byte per cycle unless stalled; a pixel is three
// bytes, a block start 1 to 11 (opcode plus four bytes per changed window).
// The front takes one word per cycle unless full, into a four-entry queue;
// full rises only when that queue is full. Reset is asynchronous and clears
// the window cache to all ones, the pixel count to zero and the opcodes to
// 42/43/44. A stalled result holds on the ports while the back end waits.
`default_nettype none

module dcs_window_pixel_writer import dcsw_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [15:0] x_start,
    input  wire logic [15:0] y_start,
    input  wire logic [15:0] block_width,
    input  wire logic [15:0] block_height,
    input  wire logic [15:0] pixel_rgb565,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             is_data,
    output logic             cs_release,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0] col_opcode_reg, col_opcode_next;
    logic [7:0] page_opcode_reg, page_opcode_next;
    logic [7:0] mw_opcode_reg, mw_opcode_next;

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    op_t        q_wr_word;
    op_t        q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        col_opcode_next  = col_opcode_reg;
        page_opcode_next = page_opcode_reg;
        mw_opcode_next   = mw_opcode_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COL_OPCODE:  col_opcode_next  = cfg_data;
                CFG_PAGE_OPCODE: page_opcode_next = cfg_data;
                CFG_MW_OPCODE:   mw_opcode_next   = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_opcode_reg  <= RST_COL_OPCODE;
            page_opcode_reg <= RST_PAGE_OPCODE;
            mw_opcode_reg   <= RST_MW_OPCODE;
        end
        else
        begin
            col_opcode_reg  <= col_opcode_next;
            page_opcode_reg <= page_opcode_next;
            mw_opcode_reg   <= mw_opcode_next;
        end
    end

    dcsw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .x_start      (x_start),
        .y_start      (y_start),
        .block_width  (block_width),
        .block_height (block_height),
        .pixel_rgb565 (pixel_rgb565),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_word       (q_wr_word)
    );

    dcsw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_word (q_wr_word),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_word (q_head),
        .q_empty (q_empty)
    );

    dcsw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .col_opcode  (col_opcode_reg),
        .page_opcode (page_opcode_reg),
        .mw_opcode   (mw_opcode_reg),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .is_data     (is_data),
        .cs_release  (cs_release),
        .last        (last)
    );

endmodule

`default_nettype wire

// File: rtl/dcsw_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module dcsw_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] out_byte,
    input wire logic       is_data,
    input wire logic       cs_release,
    input wire logic       last
);

    // a word not taken stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result word withdrawn before pop");

    // a word not taken keeps its payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(out_byte) && $stable(is_data)
                              && $stable(cs_release) && $stable(last)))
        else $error("stalled result word changed");

    // a command byte that releases chip select is the memory-write of a
    // zero-size block, which ends its item
    a_cmd_release_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_data && cs_release) |-> last)
        else $error("command byte released chip select without ending item");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result offered straight out of reset");

endmodule

bind dcs_window_pixel_writer dcsw_checker u_dcsw_checker (.*);

`default_nettype wire
